[rtl/core/chc_pkg.sv]
// Shared constants and types for the contactor hysteresis controller.
// No dependencies.
`default_nettype none

package chc_pkg;

  localparam int unsigned SocW  = 7;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [SocW-1:0]    soc_t;
  typedef logic [TimeW-1:0]   ms_t;
  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Operator command codes
  localparam cmd_t CMD_NONE    = 3'd0;
  localparam cmd_t CMD_ON      = 3'd1;
  localparam cmd_t CMD_OFF     = 3'd2;
  localparam cmd_t CMD_AUTO    = 3'd3;
  localparam cmd_t CMD_UNKNOWN = 3'd4;

  // Configuration register indexes
  localparam cfg_idx_t REG_CLOSE_SOC     = 2'd0;
  localparam cfg_idx_t REG_OPEN_SOC      = 2'd1;
  localparam cfg_idx_t REG_BOOT_HOLD_MS  = 2'd2;
  localparam cfg_idx_t REG_SWITCH_GAP_MS = 2'd3;

  // Register reset values
  localparam soc_t RST_CLOSE_SOC     = 7'd60;
  localparam soc_t RST_OPEN_SOC      = 7'd40;
  localparam ms_t  RST_BOOT_HOLD_MS  = 32'd15000;
  localparam ms_t  RST_SWITCH_GAP_MS = 32'd5000;

endpackage

`default_nettype wire

[rtl/core/contactor_hysteresis_controller_top.sv]
// Contactor hysteresis controller: command decode, SOC hysteresis and switch lockout.
// Depends on chc_pkg.
`default_nettype none

// Each request is one control pass. It is captured into an input register, the
// whole decision (operator command, SOC hysteresis, boot hold and switch-gap
// lockout) is evaluated in one short combinational stage, and the result is
// captured in an output register together with the updated contactor state.
// A new request is taken every cycle unless in_stall is high; it passes through
// the input register and then the result register, and throughput is one request
// per cycle when nothing stalls; each pass updates the contactor state that the
// next request reads. The input side stalls only when the input register is
// full and the result register cannot drain. Commands "on" and "off" latch a
// manual override at the given level, "auto" releases it, codes four to seven
// are flagged as bad and otherwise ignored. Closing is refused while now_ms is
// below boot_hold_ms (plain compare, no wrap); any change is refused until
// switch_gap_ms has passed since the last change (wrapping subtraction).
// Configuration writes take effect at once and must only be issued while no
// request is in flight.
module contactor_hysteresis_controller_top (
  input  wire                     clk,
  input  wire                     rst_n,
  // request channel
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  chc_pkg::ms_t      in_now_ms,
  input  wire  chc_pkg::soc_t     in_avg_soc,
  input  wire                     in_data_expired,
  input  wire  chc_pkg::cmd_t     in_cmd,
  // result channel
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic                    out_contactor_closed,
  output logic                    out_auto_request,
  output logic                    out_low_soc_warning,
  output logic                    out_switched,
  output logic                    out_manual_mode,
  output logic                    out_bad_command,
  // configuration
  input  wire                     cfg_wr_en,
  input  wire  chc_pkg::cfg_idx_t cfg_index,
  input  wire  [chc_pkg::CfgW-1:0] cfg_wdata
);
  import chc_pkg::*;

  // configuration registers
  soc_t close_soc_r, open_soc_r;
  ms_t  boot_hold_r, switch_gap_r;

  // input register stage
  logic s1_valid_r;
  ms_t  s1_now_r;
  soc_t s1_soc_r;
  logic s1_expired_r;
  cmd_t s1_cmd_r;

  // controller state
  logic relay_r, ovr_on_r, ovr_lvl_r;
  ms_t  last_sw_r;

  // result register
  logic out_valid_r;
  logic res_closed_r, res_req_r, res_warn_r, res_sw_r, res_manual_r, res_bad_r;

  logic out_free, s1_fire, in_fire;
  logic cmd_force, cmd_auto, cmd_bad;
  logic ovr_on_nxt, ovr_lvl_nxt;
  logic req_pre, target, gap_ok, boot_block, chg;
  logic relay_nxt, relay_mid;
  logic req_out, warn_out;
  ms_t  elapsed;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // command decode
  always_comb begin
    cmd_force = 1'b0;
    cmd_auto  = 1'b0;
    cmd_bad   = 1'b0;
    case (s1_cmd_r) inside
      CMD_ON, CMD_OFF: cmd_force = 1'b1;
      CMD_AUTO:        cmd_auto  = 1'b1;
      CMD_NONE:        ;
      default:         cmd_bad   = 1'b1;
    endcase
  end

  assign ovr_on_nxt  = cmd_force ? 1'b1 : (cmd_auto ? 1'b0 : ovr_on_r);
  assign ovr_lvl_nxt = cmd_force ? (s1_cmd_r == CMD_ON) : ovr_lvl_r;

  // SOC hysteresis against the pre-pass contactor level; only used for the
  // target when no override is active, and then the level is unchanged here
  always_comb begin
    req_pre = relay_r;
    if (s1_expired_r) begin
      req_pre = 1'b0;
    end else if (s1_soc_r > close_soc_r) begin
      req_pre = 1'b1;
    end else if (s1_soc_r < open_soc_r) begin
      req_pre = 1'b0;
    end
  end

  // a forced command and the SOC pass try the same target with the same
  // timestamp, so one switching attempt covers both
  assign target     = ovr_on_nxt ? ovr_lvl_nxt : req_pre;
  assign elapsed    = s1_now_r - last_sw_r;
  assign gap_ok     = elapsed >= switch_gap_r;
  assign boot_block = target && (s1_now_r < boot_hold_r);
  assign chg        = (target != relay_r) && !boot_block && gap_ok;
  assign relay_nxt  = chg ? target : relay_r;

  // SOC logic sees the level after a forced command's attempt
  assign relay_mid = cmd_force ? relay_nxt : relay_r;

  always_comb begin
    req_out  = relay_mid;
    warn_out = 1'b0;
    if (s1_expired_r) begin
      req_out = 1'b0;
    end else if (s1_soc_r > close_soc_r) begin
      req_out = 1'b1;
    end else if (s1_soc_r < open_soc_r) begin
      req_out  = 1'b0;
      warn_out = relay_mid;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_soc_r  <= RST_CLOSE_SOC;
      open_soc_r   <= RST_OPEN_SOC;
      boot_hold_r  <= RST_BOOT_HOLD_MS;
      switch_gap_r <= RST_SWITCH_GAP_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CLOSE_SOC:     close_soc_r  <= cfg_wdata[SocW-1:0];
        REG_OPEN_SOC:      open_soc_r   <= cfg_wdata[SocW-1:0];
        REG_BOOT_HOLD_MS:  boot_hold_r  <= cfg_wdata[TimeW-1:0];
        REG_SWITCH_GAP_MS: switch_gap_r <= cfg_wdata[TimeW-1:0];
        default:           ;
      endcase
    end
  end

  // input register: load on accept, drop when passed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r     <= in_now_ms;
      s1_soc_r     <= in_avg_soc;
      s1_expired_r <= in_data_expired;
      s1_cmd_r     <= in_cmd;
    end
  end

  // controller state advances with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r   <= 1'b0;
      ovr_on_r  <= 1'b0;
      ovr_lvl_r <= 1'b0;
      last_sw_r <= '0;
    end else if (s1_fire) begin
      relay_r   <= relay_nxt;
      ovr_on_r  <= ovr_on_nxt;
      ovr_lvl_r <= ovr_lvl_nxt;
      if (chg) begin
        last_sw_r <= s1_now_r;
      end
    end
  end

  // result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_closed_r <= relay_nxt;
      res_req_r    <= req_out;
      res_warn_r   <= warn_out;
      res_sw_r     <= chg;
      res_manual_r <= ovr_on_nxt;
      res_bad_r    <= cmd_bad;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_contactor_closed = res_closed_r;
  assign out_auto_request     = res_req_r;
  assign out_low_soc_warning  = res_warn_r;
  assign out_switched         = res_sw_r;
  assign out_manual_mode      = res_manual_r;
  assign out_bad_command      = res_bad_r;

  // a reported switch really flips the contactor
  a_switch_flips : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && chg) |=> (relay_r != $past(relay_r)))
    else $error("switch reported without contactor change");

  // contactor only moves when a pass completes
  a_relay_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(relay_r))
    else $error("contactor changed outside a pass");

  // never close during boot hold
  a_boot_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && chg && target) |-> (s1_now_r >= boot_hold_r))
    else $error("contactor closed during boot hold");

  // presented result agrees with the live state
  a_manual_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_manual_mode == ovr_on_r && out_contactor_closed == relay_r))
    else $error("result disagrees with controller state");

endmodule

`default_nettype wire
